@@ src/mtas_pkg.sv @@
// Package for the markup-to-ANSI stream unit: types, character codes, lookups, microcode.
package mtas_pkg;

	// character codes
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_M         = 8'h6D;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_PIPE      = 8'h7C;
	localparam logic [7:0] NON_ASCII_MIN = 8'h80;

	// pending color mark
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_FG   = 2'd1,
		PEND_BG   = 2'd2
	} pend_t;

	// SGR code held as decimal digits: hundreds (0 or 1), tens, ones
	typedef struct packed {
		logic       h;
		logic [3:0] t;
		logic [3:0] o;
	} code_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} style_hit_t;

	typedef struct packed {
		logic  hit;
		code_t fg;
	} color_hit_t;

	// one accepted byte, ready for the sequencer: up to three segments
	// segment A: code, segment B: code or character, segment C: code
	typedef struct packed {
		code_t      code_a;
		code_t      code_b;
		logic [7:0] char_b;
		logic       b_is_char;
		logic       b_bad;
		code_t      code_c;
		logic [2:0] mask;
		logic       last;
	} job_t;

	// microcode
	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_SEL   = 4'd1;
	localparam step_t STEP_ESC   = 4'd2;
	localparam step_t STEP_LB    = 4'd3;
	localparam step_t STEP_HCHK  = 4'd4;
	localparam step_t STEP_HUND  = 4'd5;
	localparam step_t STEP_TENS  = 4'd6;
	localparam step_t STEP_ONES  = 4'd7;
	localparam step_t STEP_FIN   = 4'd8;
	localparam step_t STEP_CHAR  = 4'd9;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_ESC,
		SRC_LB,
		SRC_HUND,
		SRC_TENS,
		SRC_ONES,
		SRC_FIN,
		SRC_CHAR
	} src_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_START,
		C_CHAR,
		C_LT10,
		C_LT100,
		C_MORE
	} cond_t;

	typedef struct packed {
		src_t  src;
		cond_t cond;
		step_t target;
		step_t alt;
		logic  retire;
	} ctrl_word_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic go;
		logic start;
		logic cur_char;
		logic lt10;
		logic lt100;
		logic more;
		logic any_slot;
	} seq_status_t;

	function automatic code_t mk_code(input logic h, input logic [3:0] t, input logic [3:0] o);
		code_t c;
		c.h = h;
		c.t = t;
		c.o = o;
		return c;
	endfunction

	// control store: next = cond ? target : alt
	function automatic ctrl_word_t ucode(input step_t pc);
		ctrl_word_t w;
		case (pc)
			STEP_IDLE: w = '{SRC_NONE, C_START,  STEP_SEL,  STEP_IDLE, 1'b0};
			STEP_SEL:  w = '{SRC_NONE, C_CHAR,   STEP_CHAR, STEP_ESC,  1'b0};
			STEP_ESC:  w = '{SRC_ESC,  C_ALWAYS, STEP_LB,   STEP_LB,   1'b0};
			STEP_LB:   w = '{SRC_LB,   C_LT10,   STEP_ONES, STEP_HCHK, 1'b0};
			STEP_HCHK: w = '{SRC_NONE, C_LT100,  STEP_TENS, STEP_HUND, 1'b0};
			STEP_HUND: w = '{SRC_HUND, C_ALWAYS, STEP_TENS, STEP_TENS, 1'b0};
			STEP_TENS: w = '{SRC_TENS, C_ALWAYS, STEP_ONES, STEP_ONES, 1'b0};
			STEP_ONES: w = '{SRC_ONES, C_ALWAYS, STEP_FIN,  STEP_FIN,  1'b0};
			STEP_FIN:  w = '{SRC_FIN,  C_MORE,   STEP_SEL,  STEP_IDLE, 1'b1};
			STEP_CHAR: w = '{SRC_CHAR, C_MORE,   STEP_SEL,  STEP_IDLE, 1'b1};
			default:   w = '{SRC_NONE, C_ALWAYS, STEP_IDLE, STEP_IDLE, 1'b0};
		endcase
		return w;
	endfunction

	// style marks: # ~ * _ @ $ ` %
	function automatic style_hit_t style_lookup(input logic [7:0] c);
		style_hit_t s;
		s.hit = 1'b1;
		case (c)
			8'h23:   s.idx = 3'd0;
			8'h7E:   s.idx = 3'd1;
			8'h2A:   s.idx = 3'd2;
			8'h5F:   s.idx = 3'd3;
			8'h40:   s.idx = 3'd4;
			8'h24:   s.idx = 3'd5;
			8'h60:   s.idx = 3'd6;
			8'h25:   s.idx = 3'd7;
			default: begin
				s.hit = 1'b0;
				s.idx = 3'd0;
			end
		endcase
		return s;
	endfunction

	function automatic code_t style_code(input logic [2:0] idx, input logic on);
		code_t c;
		case (idx)
			3'd0:    c = on ? mk_code(1'b0, 4'd0, 4'd1) : mk_code(1'b0, 4'd2, 4'd2);
			3'd1:    c = on ? mk_code(1'b0, 4'd0, 4'd2) : mk_code(1'b0, 4'd2, 4'd2);
			3'd2:    c = on ? mk_code(1'b0, 4'd0, 4'd3) : mk_code(1'b0, 4'd2, 4'd3);
			3'd3:    c = on ? mk_code(1'b0, 4'd0, 4'd4) : mk_code(1'b0, 4'd2, 4'd4);
			3'd4:    c = on ? mk_code(1'b0, 4'd0, 4'd5) : mk_code(1'b0, 4'd2, 4'd5);
			3'd5:    c = on ? mk_code(1'b0, 4'd0, 4'd7) : mk_code(1'b0, 4'd2, 4'd7);
			3'd6:    c = on ? mk_code(1'b0, 4'd0, 4'd8) : mk_code(1'b0, 4'd2, 4'd8);
			default: c = on ? mk_code(1'b0, 4'd0, 4'd9) : mk_code(1'b0, 4'd2, 4'd9);
		endcase
		return c;
	endfunction

	// color letters, foreground code
	function automatic color_hit_t color_lookup(input logic [7:0] c);
		color_hit_t r;
		r.hit = 1'b1;
		case (c)
			8'h6C:   r.fg = mk_code(1'b0, 4'd3, 4'd0);
			8'h72:   r.fg = mk_code(1'b0, 4'd3, 4'd1);
			8'h67:   r.fg = mk_code(1'b0, 4'd3, 4'd2);
			8'h79:   r.fg = mk_code(1'b0, 4'd3, 4'd3);
			8'h62:   r.fg = mk_code(1'b0, 4'd3, 4'd4);
			8'h6D:   r.fg = mk_code(1'b0, 4'd3, 4'd5);
			8'h63:   r.fg = mk_code(1'b0, 4'd3, 4'd6);
			8'h4C:   r.fg = mk_code(1'b0, 4'd9, 4'd7);
			8'h52:   r.fg = mk_code(1'b0, 4'd9, 4'd1);
			8'h47:   r.fg = mk_code(1'b0, 4'd9, 4'd2);
			8'h59:   r.fg = mk_code(1'b0, 4'd9, 4'd3);
			8'h42:   r.fg = mk_code(1'b0, 4'd9, 4'd4);
			8'h4D:   r.fg = mk_code(1'b0, 4'd9, 4'd5);
			8'h43:   r.fg = mk_code(1'b0, 4'd9, 4'd6);
			default: begin
				r.hit = 1'b0;
				r.fg  = mk_code(1'b0, 4'd0, 4'd0);
			end
		endcase
		return r;
	endfunction

	// background code is foreground plus ten, in decimal digits
	function automatic code_t bg_of(input code_t fg);
		code_t c;
		c = fg;
		if (fg.t == 4'd9) begin
			c.h = 1'b1;
			c.t = 4'd0;
		end else begin
			c.t = fg.t + 4'd1;
		end
		return c;
	endfunction

	function automatic code_t reset_code(input pend_t p);
		code_t c;
		case (p)
			PEND_FG: c = mk_code(1'b0, 4'd3, 4'd9);
			default: c = mk_code(1'b0, 4'd4, 4'd9);
		endcase
		return c;
	endfunction

endpackage

@@ src/mtas_if.sv @@
// Stream interfaces: markup bytes in, ANSI text bytes out.
interface mtas_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last_char;

	modport source (output valid, ch, last_char, input ready);
	modport sink (input valid, ch, last_char, output ready);
endinterface

interface mtas_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       text_end;
	logic       bad_byte;

	modport source (output valid, out_byte, run_end, text_end, bad_byte, input ready);
	modport sink (input valid, out_byte, run_end, text_end, bad_byte, output ready);
endinterface

@@ src/mtas_decode.sv @@
// Input byte decoder: markup state, format register and segment plan per byte.
module mtas_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              take,
	input  logic [7:0]        ch,
	input  logic              last_char,
	output mtas_pkg::job_t    job
);
	import mtas_pkg::*;

	logic [7:0] flags_q, flags_d;
	pend_t      pend_q, pend_d;
	logic       lit_q, lit_d;
	logic       fmt_q;

	logic       a_en, b_en, c_en, run_plain;
	logic [7:0] mark;
	style_hit_t sty;
	color_hit_t col;

	// plan the output segments and the next markup state
	always_comb begin
		sty       = style_lookup(ch);
		col       = color_lookup(ch);
		mark      = (pend_q == PEND_FG) ? CH_CARET : CH_PIPE;
		flags_d   = flags_q;
		pend_d    = pend_q;
		lit_d     = lit_q;
		a_en      = 1'b0;
		b_en      = 1'b0;
		c_en      = 1'b0;
		run_plain = 1'b0;
		job       = '0;
		job.char_b = ch;
		job.last   = last_char;

		if (ch >= NON_ASCII_MIN) begin
			// flagged byte, state untouched
			b_en          = 1'b1;
			job.b_is_char = 1'b1;
			job.char_b    = 8'h00;
			job.b_bad     = 1'b1;
		end else if (lit_q) begin
			lit_d         = 1'b0;
			b_en          = 1'b1;
			job.b_is_char = 1'b1;
		end else begin
			run_plain = 1'b1;
			if (pend_q != PEND_NONE) begin
				if (ch == mark) begin
					run_plain = 1'b0;
				end else if (col.hit) begin
					a_en       = fmt_q;
					job.code_a = (pend_q == PEND_FG) ? col.fg : bg_of(col.fg);
					pend_d     = PEND_NONE;
					run_plain  = 1'b0;
				end else begin
					a_en       = fmt_q;
					job.code_a = reset_code(pend_q);
					pend_d     = PEND_NONE;
				end
			end
			if (run_plain) begin
				if (ch == CH_BACKSLASH) begin
					lit_d = 1'b1;
				end else if (ch == CH_CARET) begin
					pend_d = PEND_FG;
				end else if (ch == CH_PIPE) begin
					pend_d = PEND_BG;
				end else if (sty.hit) begin
					flags_d[sty.idx] = ~flags_q[sty.idx];
					b_en             = fmt_q;
					job.code_b       = style_code(sty.idx, ~flags_q[sty.idx]);
				end else begin
					b_en          = 1'b1;
					job.b_is_char = 1'b1;
				end
			end
		end

		// text end flushes a pending mark
		if (last_char) begin
			c_en       = fmt_q && (pend_d != PEND_NONE);
			job.code_c = reset_code(pend_d);
		end
		job.mask = {c_en, b_en, a_en};
	end

	// markup state, cleared at text end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			pend_q  <= PEND_NONE;
			lit_q   <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				flags_q <= '0;
				pend_q  <= PEND_NONE;
				lit_q   <= 1'b0;
			end else begin
				flags_q <= flags_d;
				pend_q  <= pend_d;
				lit_q   <= lit_d;
			end
		end
	end

	// format enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b1;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

endmodule

@@ src/mtas_sequencer.sv @@
// Microcode sequencer: step counter, control store and jump logic.
module mtas_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mtas_pkg::seq_status_t st,
	output mtas_pkg::ctrl_word_t  word,
	output logic                  idle
);
	import mtas_pkg::*;

	step_t pc_q, pc_d;
	logic  cond_hit;

	// condition select and next step
	always_comb begin
		word = ucode(pc_q);
		case (word.cond)
			C_ALWAYS: cond_hit = 1'b1;
			C_START:  cond_hit = st.start;
			C_CHAR:   cond_hit = st.cur_char;
			C_LT10:   cond_hit = st.lt10;
			C_LT100:  cond_hit = st.lt100;
			C_MORE:   cond_hit = st.more;
			default:  cond_hit = 1'b0;
		endcase
		if (st.go) begin
			pc_d = cond_hit ? word.target : word.alt;
		end else begin
			pc_d = pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign idle = (pc_q == STEP_IDLE);

endmodule

@@ src/mtas_datapath.sv @@
// Datapath: segment registers, digit and byte select, output register.
module mtas_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  mtas_pkg::job_t        job,
	input  mtas_pkg::ctrl_word_t  word,
	output mtas_pkg::seq_status_t st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_end,
	output logic                  text_end,
	output logic                  bad_byte
);
	import mtas_pkg::*;

	job_t       job_q;
	logic [2:0] mask_q, mask_rest;
	code_t      cur;
	logic       emit, go, is_b;
	logic [7:0] byte_sel;
	logic       fin_sel;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q, text_end_q, bad_q;

	// current segment is the lowest one still set
	always_comb begin
		mask_rest = mask_q & (mask_q - 3'd1);
		is_b      = !mask_q[0] && mask_q[1];
		if (mask_q[0]) begin
			cur = job_q.code_a;
		end else if (mask_q[1]) begin
			cur = job_q.code_b;
		end else begin
			cur = job_q.code_c;
		end
	end

	// byte select for the step
	always_comb begin
		case (word.src)
			SRC_ESC:  byte_sel = CH_ESC;
			SRC_LB:   byte_sel = CH_LBRACKET;
			SRC_HUND: byte_sel = CH_ZERO + {7'd0, cur.h};
			SRC_TENS: byte_sel = CH_ZERO + {4'd0, cur.t};
			SRC_ONES: byte_sel = CH_ZERO + {4'd0, cur.o};
			SRC_FIN:  byte_sel = CH_M;
			SRC_CHAR: byte_sel = job_q.char_b;
			default:  byte_sel = 8'h00;
		endcase
		emit    = (word.src != SRC_NONE);
		fin_sel = (word.src == SRC_FIN) || (word.src == SRC_CHAR);
		go      = !emit || !valid_q || out_ready;
	end

	always_comb begin
		st.go       = go;
		st.start    = load && (job.mask != 3'd0);
		st.cur_char = is_b && job_q.b_is_char;
		st.lt10     = !cur.h && (cur.t == 4'd0);
		st.lt100    = !cur.h;
		st.more     = (mask_rest != 3'd0);
		st.any_slot = (mask_q != 3'd0);
	end

	// segment registers
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= job.mask;
		end else if (go && word.retire) begin
			mask_q <= mask_rest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit && go) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go) begin
			byte_q     <= byte_sel;
			run_end_q  <= fin_sel && (mask_rest == 3'd0);
			text_end_q <= fin_sel && (mask_rest == 3'd0) && job_q.last;
			bad_q      <= (word.src == SRC_CHAR) && job_q.b_bad;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_end   = run_end_q;
	assign text_end  = text_end_q;
	assign bad_byte  = bad_q;

endmodule

@@ src/markup_to_ansi_stream_unit.sv @@
// Top level of the markup-to-ANSI stream unit.
//
// markup carries one text byte per beat (ch, last_char); ansi carries one output
// byte per beat with run_end, text_end and bad_byte. Both use valid/ready.
// cfg_we/cfg_wdata write format_enable (reset 1); write only while idle.
// An accepted byte is split into up to three segments (color code, character
// or style code, flush code). A microcoded step counter walks each segment,
// one step per cycle while the output is not stalled, one output byte per
// emitting step. Each segment takes a select step, then a character step or
// ESC, [, a digit check for codes of two digits or more, the digits the code
// needs, and m. A byte with no segments leaves the step counter idle. The
// first output beat of a byte is registered from its first emitting step.
// markup.ready is high only while the step counter is idle; the last output
// byte may still sit in the output register then.
// When ansi.ready is low and the output register is full, the step counter
// holds on its emitting step; the output register keeps its beat until taken.
// Reset clears the markup state, step counter and output valid, and sets
// format_enable to 1.
module markup_to_ansi_stream_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	mtas_in_if.sink     markup,
	mtas_out_if.source  ansi
);
	import mtas_pkg::*;

	job_t        job;
	ctrl_word_t  word;
	seq_status_t st;
	logic        idle;
	logic        take;

	assign markup.ready = idle;
	assign take         = markup.valid && idle;

	mtas_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.ch        (markup.ch),
		.last_char (markup.last_char),
		.job       (job)
	);

	mtas_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.word   (word),
		.idle   (idle)
	);

	mtas_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.job       (job),
		.word      (word),
		.st        (st),
		.out_valid (ansi.valid),
		.out_ready (ansi.ready),
		.out_byte  (ansi.out_byte),
		.run_end   (ansi.run_end),
		.text_end  (ansi.text_end),
		.bad_byte  (ansi.bad_byte)
	);

`ifndef SYNTHESIS
	a_text_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		ansi.valid && ansi.text_end |-> ansi.run_end)
		else $error("text_end without run_end");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ansi.valid && ansi.bad_byte |-> ansi.out_byte == 8'h00)
		else $error("flagged beat carries data");

	a_idle_no_segments: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !st.any_slot)
		else $error("segments left while sequencer idle");

	a_emit_needs_segment: assert property (@(posedge clk) disable iff (!arst_n)
		word.src != SRC_NONE |-> st.any_slot)
		else $error("emit step with no segment");
`endif

endmodule

@@ verif/tb_markup_to_ansi_stream_unit.sv @@
// Self-checking testbench for markup_to_ansi_stream_unit: directed table, then random texts.
module tb_markup_to_ansi_stream_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mtas_pkg::*;

	localparam int FG_RESET_SGR  = 39;
	localparam int BG_RESET_SGR  = 49;
	localparam int BG_SGR_OFFSET = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 120;
	localparam int IDLE_LIMIT    = 4000;
	localparam int PHASE_ITEMS   = 112;
	localparam int NUM_PHASES    = 4;
	localparam int SHOWN_ERRORS  = 10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       text_end;
		logic       bad_byte;
	} ansi_beat_t;

	// one markup byte; typed rows carry their single expected beat
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic [7:0] exp_byte;
		logic       exp_bad;
	} markup_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	mtas_in_if  markup_bus ();
	mtas_out_if ansi_bus ();

	markup_to_ansi_stream_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.markup    (markup_bus),
		.ansi      (ansi_bus)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0] style_on_mask;
	pend_t      color_mark;
	logic       literal_armed;
	logic       fmt_model;

	ansi_beat_t   ansi_expected [$];
	markup_item_t markup_stream [$];
	markup_item_t offered;

	int mismatch_count = 0;
	int markup_count = 0;
	int ansi_count = 0;
	int texts_closed = 0;
	int bad_seen = 0;
	int burst_left = 0;
	bit hold_done = 0;

	// directed table: extremes, every style, color marks, literals, text end cases
	markup_item_t directed_rows [27] = '{
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},   // NUL passes through
		{8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},   // highest ASCII
		{8'h80, 1'b0, 1'b1, 8'h00, 1'b1},   // lowest non-ASCII
		{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},   // non-ASCII ending a text
		{8'h23, 1'b0, 1'b0, 8'h00, 1'b0},   // # bold
		{8'h7E, 1'b0, 1'b0, 8'h00, 1'b0},   // ~ dim
		{8'h2A, 1'b0, 1'b0, 8'h00, 1'b0},   // * italic
		{8'h5F, 1'b0, 1'b0, 8'h00, 1'b0},   // _ underline
		{8'h40, 1'b0, 1'b0, 8'h00, 1'b0},   // @ blink
		{8'h24, 1'b0, 1'b0, 8'h00, 1'b0},   // $ inverse
		{8'h60, 1'b0, 1'b0, 8'h00, 1'b0},   // backtick hidden
		{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},   // % strike
		{8'h23, 1'b0, 1'b0, 8'h00, 1'b0},   // bold off
		{8'h5E, 1'b0, 1'b0, 8'h00, 1'b0},   // ^ fg mark
		{8'h5E, 1'b0, 1'b0, 8'h00, 1'b0},   // repeated mark collapses
		{8'h52, 1'b0, 1'b0, 8'h00, 1'b0},   // R bright red fg
		{8'h7C, 1'b0, 1'b0, 8'h00, 1'b0},   // | bg mark
		{8'h4C, 1'b0, 1'b0, 8'h00, 1'b0},   // L three-digit bg code
		{8'h7C, 1'b0, 1'b0, 8'h00, 1'b0},
		{8'h78, 1'b0, 1'b0, 8'h00, 1'b0},   // x is no color: bg reset, then x
		{8'h5C, 1'b0, 1'b0, 8'h00, 1'b0},   // backslash arms literal
		{8'hC3, 1'b0, 1'b1, 8'h00, 1'b1},   // non-ASCII leaves literal armed
		{8'h62, 1'b0, 1'b0, 8'h00, 1'b0},   // b taken literally
		{8'h5E, 1'b0, 1'b0, 8'h00, 1'b0},
		{8'h5C, 1'b1, 1'b0, 8'h00, 1'b0},   // fg reset, then backslash dropped at end
		{8'h5C, 1'b1, 1'b0, 8'h00, 1'b0},   // trailing backslash: no output
		{8'h41, 1'b1, 1'b1, 8'h41, 1'b0}    // plain A ending a text
	};

	function automatic int style_slot(input logic [7:0] c);
		case (c)
			8'h23:   return 0;
			8'h7E:   return 1;
			8'h2A:   return 2;
			8'h5F:   return 3;
			8'h40:   return 4;
			8'h24:   return 5;
			8'h60:   return 6;
			8'h25:   return 7;
			default: return -1;
		endcase
	endfunction

	// SGR number for a style turning on or off
	function automatic int style_sgr(input int slot, input logic turn_on);
		if (turn_on)
			return (slot < 5) ? slot + 1 : slot + 2;
		if (slot == 0)
			return 22;
		return (slot < 5) ? slot + 21 : slot + 22;
	endfunction

	// foreground SGR for a color letter, -1 if none
	function automatic int color_fg_sgr(input logic [7:0] c);
		case (c)
			"l":     return 30;
			"r":     return 31;
			"g":     return 32;
			"y":     return 33;
			"b":     return 34;
			"m":     return 35;
			"c":     return 36;
			"L":     return 97;
			"R":     return 91;
			"G":     return 92;
			"Y":     return 93;
			"B":     return 94;
			"M":     return 95;
			"C":     return 96;
			default: return -1;
		endcase
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic bad);
		ansi_beat_t beat;
		beat.out_byte = b;
		beat.run_end  = 1'b0;
		beat.text_end = 1'b0;
		beat.bad_byte = bad;
		ansi_expected.push_back(beat);
	endtask

	// ESC [ digits m, only while formatting is on
	task automatic emit_sgr(input int code);
		if (fmt_model) begin
			push_beat(CH_ESC, 1'b0);
			push_beat(CH_LBRACKET, 1'b0);
			if (code >= 100)
				push_beat(8'(CH_ZERO + code / 100), 1'b0);
			if (code >= 10)
				push_beat(8'(CH_ZERO + (code / 10) % 10), 1'b0);
			push_beat(8'(CH_ZERO + code % 10), 1'b0);
			push_beat(CH_M, 1'b0);
		end
	endtask

	task automatic emit_color_reset(input pend_t which);
		emit_sgr(which == PEND_FG ? FG_RESET_SGR : BG_RESET_SGR);
	endtask

	// expected ANSI bytes for one accepted markup byte
	task automatic predict_ansi_bytes(input logic [7:0] c, input logic last);
		int first;
		int slot;
		int fg;
		bit consumed;
		ansi_beat_t tail;
		first = ansi_expected.size();
		consumed = 0;
		if (c >= NON_ASCII_MIN) begin
			push_beat(8'h00, 1'b1);
		end else if (literal_armed) begin
			literal_armed = 1'b0;
			push_beat(c, 1'b0);
		end else begin
			// a waiting color mark eats its repeat or a color letter
			if (color_mark != PEND_NONE) begin
				fg = color_fg_sgr(c);
				if (c == (color_mark == PEND_FG ? CH_CARET : CH_PIPE)) begin
					consumed = 1;
				end else if (fg >= 0) begin
					emit_sgr(color_mark == PEND_FG ? fg : fg + BG_SGR_OFFSET);
					color_mark = PEND_NONE;
					consumed = 1;
				end else begin
					emit_color_reset(color_mark);
					color_mark = PEND_NONE;
				end
			end
			if (!consumed) begin
				slot = style_slot(c);
				if (c == CH_BACKSLASH) begin
					literal_armed = 1'b1;
				end else if (c == CH_CARET) begin
					color_mark = PEND_FG;
				end else if (c == CH_PIPE) begin
					color_mark = PEND_BG;
				end else if (slot >= 0) begin
					style_on_mask[slot] = ~style_on_mask[slot];
					emit_sgr(style_sgr(slot, style_on_mask[slot]));
				end else begin
					push_beat(c, 1'b0);
				end
			end
		end
		// text end flushes a waiting mark and clears the text state
		if (last) begin
			if (color_mark != PEND_NONE)
				emit_color_reset(color_mark);
			style_on_mask = '0;
			color_mark = PEND_NONE;
			literal_armed = 1'b0;
		end
		if (ansi_expected.size() > first) begin
			tail = ansi_expected.pop_back();
			tail.run_end = 1'b1;
			tail.text_end = last;
			ansi_expected.push_back(tail);
		end
	endtask

	task automatic note_failure(input bit has_want, input ansi_beat_t want, input ansi_beat_t got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRORS) begin
			if (has_want)
				$display("%0t mismatch: want %h/%b/%b/%b, got %h/%b/%b/%b",
					$realtime, want.out_byte, want.run_end, want.text_end, want.bad_byte,
					got.out_byte, got.run_end, got.text_end, got.bad_byte);
			else
				$display("%0t unexpected beat: byte %h run %b text %b bad %b",
					$realtime, got.out_byte, got.run_end, got.text_end, got.bad_byte);
		end
	endtask

	// scoreboard: check ANSI beats, then predict for the markup beat of this edge
	always @(posedge clk) begin
		ansi_beat_t got;
		ansi_beat_t want;
		int mark;
		if (arst_n) begin
			if (ansi_bus.valid && ansi_bus.ready) begin
				got.out_byte = ansi_bus.out_byte;
				got.run_end  = ansi_bus.run_end;
				got.text_end = ansi_bus.text_end;
				got.bad_byte = ansi_bus.bad_byte;
				ansi_count++;
				if (got.bad_byte)
					bad_seen++;
				if (ansi_expected.size() == 0) begin
					note_failure(1'b0, '0, got);
				end else begin
					want = ansi_expected.pop_front();
					if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
					    got.text_end !== want.text_end || got.bad_byte !== want.bad_byte)
						note_failure(1'b1, want, got);
				end
			end
			if (markup_bus.valid && markup_bus.ready) begin
				markup_count++;
				if (markup_bus.last_char)
					texts_closed++;
				mark = ansi_expected.size();
				predict_ansi_bytes(markup_bus.ch, markup_bus.last_char);
				// typed rows replace the prediction with their own beat
				if (offered.typed) begin
					while (ansi_expected.size() > mark)
						void'(ansi_expected.pop_back());
					want.out_byte = offered.exp_byte;
					want.run_end  = 1'b1;
					want.text_end = markup_bus.last_char;
					want.bad_byte = offered.exp_bad;
					ansi_expected.push_back(want);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		int idle_cycles;
		if (arst_n) begin
			if ((markup_bus.valid && markup_bus.ready) || (ansi_bus.valid && ansi_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d expected beats left",
					IDLE_LIMIT, ansi_expected.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: stall patterns that change over time, plus one long hold-off
	initial begin
		int rx_tick;
		int rx_mode;
		rx_tick = 0;
		rx_mode = 0;
		ansi_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && markup_count >= HOLD_AFTER) begin
				hold_done = 1;
				ansi_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rx_tick++;
			if (rx_tick % 150 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0:       ansi_bus.ready <= 1'b1;
				1:       ansi_bus.ready <= ($urandom_range(0, 3) != 0);
				default: ansi_bus.ready <= ((rx_tick % 9) >= 3);
			endcase
		end
	end

	// offer one markup beat in bursts with random gaps; returns at a falling edge
	task automatic offer_markup_byte(input markup_item_t it);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				markup_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		offered = it;
		markup_bus.valid <= 1'b1;
		markup_bus.ch <= it.ch;
		markup_bus.last_char <= it.last;
		do
			@(posedge clk);
		while (!markup_bus.ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_queued_markup();
		while (markup_stream.size() > 0)
			offer_markup_byte(markup_stream.pop_front());
		markup_bus.valid <= 1'b0;
		burst_left = 0;
	endtask

	// register write only once every expected beat is out and the unit has settled
	task automatic program_format(input logic en);
		while (ansi_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		fmt_model = en;
	endtask

	task automatic queue_text_byte(input logic [7:0] c);
		markup_item_t it;
		it = '0;
		it.ch = c;
		it.last = ($urandom_range(0, 15) == 0);
		markup_stream.push_back(it);
	endtask

	function automatic logic [7:0] pick_style_mark();
		case ($urandom_range(0, 7))
			0:       return 8'h23;
			1:       return 8'h7E;
			2:       return 8'h2A;
			3:       return 8'h5F;
			4:       return 8'h40;
			5:       return 8'h24;
			6:       return 8'h60;
			default: return 8'h25;
		endcase
	endfunction

	function automatic logic [7:0] pick_color_letter();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h41, 8'h7A));
		while (color_fg_sgr(c) < 0);
		return c;
	endfunction

	// mostly well-formed markup with random content, some noise and broken marks
	task automatic compose_random_text(input int count);
		logic [7:0] mark;
		int sel;
		while (markup_stream.size() < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				queue_text_byte(8'($urandom_range(8'h20, 8'h7E)));
			end else if (sel < 40) begin
				queue_text_byte(8'($urandom_range(0, 127)));
			end else if (sel < 55) begin
				queue_text_byte(pick_style_mark());
			end else if (sel < 75) begin
				mark = $urandom_range(0, 1) ? CH_CARET : CH_PIPE;
				repeat ($urandom_range(1, 3)) queue_text_byte(mark);
				case ($urandom_range(0, 9))
					0:       queue_text_byte(8'($urandom_range(0, 127)));
					1:       queue_text_byte(mark == CH_CARET ? CH_PIPE : CH_CARET);
					2:       queue_text_byte(pick_style_mark());
					default: queue_text_byte(pick_color_letter());
				endcase
			end else if (sel < 85) begin
				queue_text_byte(CH_BACKSLASH);
				queue_text_byte(8'($urandom_range(0, 255)));
			end else if (sel < 90) begin
				queue_text_byte(8'($urandom_range(8'h80, 8'hFF)));
			end else begin
				queue_text_byte(8'($urandom_range(8'h61, 8'h7A)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		markup_bus.valid = 1'b0;
		markup_bus.ch = 8'h00;
		markup_bus.last_char = 1'b0;
		offered = '0;
		style_on_mask = '0;
		color_mark = PEND_NONE;
		literal_armed = 1'b0;
		fmt_model = 1'b1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table with formatting on
		program_format(1'b1);
		foreach (directed_rows[i])
			markup_stream.push_back(directed_rows[i]);
		send_queued_markup();

		// random phases, formatting toggled between them
		for (int p = 0; p < NUM_PHASES; p++) begin
			program_format(p % 2 == 0 ? 1'b0 : 1'b1);
			compose_random_text(PHASE_ITEMS);
			send_queued_markup();
		end

		while (ansi_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ansi_expected.size() != 0)
			mismatch_count++;

		$display("Sent %0d markup bytes over %0d closed texts, formatting on and off in turn.",
			markup_count, texts_closed);
		$display("Checked %0d ANSI bytes, %0d non-ASCII flags, %0d errors.",
			ansi_count, bad_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
